[rtl/core/scrs_pkg.sv]
// Shared types and constants for the two-channel serial controller register subset.
// No dependencies; used by every module under rtl/core.
package scrs_pkg;

  // Item opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;

  // Control-port read registers
  localparam logic [3:0] RR_STATUS   = 4'd0;
  localparam logic [3:0] RR_ERROR    = 4'd1;
  localparam logic [3:0] RR_PENDING  = 4'd3;

  // Control-port write registers
  localparam logic [3:0] WR_POINTER  = 4'd0;
  localparam logic [3:0] WR_INT_MODE = 4'd1;
  localparam logic [3:0] WR_RX_CTRL  = 4'd3;
  localparam logic [3:0] WR_TX_CTRL  = 4'd5;
  localparam logic [3:0] WR_MASTER   = 4'd9;

  // Commands carried in bits 5..3 of a pointer write
  localparam logic [2:0] CMD_POINT_HIGH = 3'd1;
  localparam logic [2:0] CMD_ERR_RESET  = 3'd6;

  // Bit positions in a register 9 write
  localparam int unsigned MIE_BIT     = 3;
  localparam int unsigned RESET_CH1_BIT = 6;
  localparam int unsigned RESET_CH0_BIT = 7;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] bus_address;
    logic [7:0] data_byte;
    logic       rx_channel;
    logic       debug_access;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] irq_vector_bits;
    logic       master_int_on;
  } res_t;

  // Per-channel strobes, already qualified by transfer and debug access
  typedef struct packed {
    logic       rd_data;
    logic       rd_ctl;
    logic       wr_ctl;
    logic       rx;
    logic       clr;
    logic [7:0] data;
  } chan_ctl_t;

  typedef struct packed {
    logic [7:0] head;
    logic       fill_nz;
    logic       overrun;
    logic       pending;
    logic       pending_nxt;
    logic [3:0] pointer;
    logic       rx_on;
    logic       tx_ie;
    logic       tx_on;
  } chan_stat_t;

  function automatic logic [7:0] pend_bits(input logic ch1, input logic ch0);
    pend_bits = {2'b00, ch0, 2'b00, ch1, 2'b00};
  endfunction

endpackage

[rtl/core/scrs_chan.sv]
// One channel: receive FIFO, flags, enables and register pointer with next-state logic.
// Depends on scrs_pkg.
module scrs_chan #(
  parameter int DEPTH = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  scrs_pkg::chan_ctl_t   ctl,
  output scrs_pkg::chan_stat_t  stat
);

  localparam int FW = $clog2(DEPTH + 1);

  logic [7:0]    fifo_r   [DEPTH];
  logic [7:0]    fifo_nxt [DEPTH];
  logic [FW-1:0] fill_r, fill_nxt;
  logic          ovr_r, ovr_nxt;
  logic          pend_r, pend_nxt;
  logic [3:0]    ptr_r, ptr_nxt;
  logic          txie_r, txie_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic          rxon_r, rxon_nxt;
  logic          txon_r, txon_nxt;
  logic          pop;

  assign pop = ctl.rd_data && (fill_r != '0);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      fifo_nxt[i] = fifo_r[i];
    end
    fill_nxt = fill_r;
    ovr_nxt  = ovr_r;
    pend_nxt = pend_r;
    ptr_nxt  = ptr_r;
    txie_nxt = txie_r;
    mode_nxt = mode_r;
    rxon_nxt = rxon_r;
    txon_nxt = txon_r;

    // advance the FIFO one place, zero-filling the tail
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        fifo_nxt[i] = fifo_r[i + 1];
      end
      fifo_nxt[DEPTH-1] = 8'h00;
      fill_nxt = fill_r - FW'(1);
      if (fill_r == FW'(1)) begin
        pend_nxt = 1'b0;
      end
    end

    if (ctl.rd_ctl) begin
      ptr_nxt = scrs_pkg::WR_POINTER;
    end

    if (ctl.wr_ctl) begin
      if (ptr_r == scrs_pkg::WR_POINTER) begin
        ptr_nxt = {ctl.data[5:3] == scrs_pkg::CMD_POINT_HIGH, ctl.data[2:0]};
        if (ctl.data[5:3] == scrs_pkg::CMD_ERR_RESET) begin
          ovr_nxt = 1'b0;
        end
      end else begin
        unique case (ptr_r)
          scrs_pkg::WR_INT_MODE: begin
            txie_nxt = ctl.data[1];
            mode_nxt = ctl.data[4:3];
          end
          scrs_pkg::WR_RX_CTRL: rxon_nxt = ctl.data[0];
          scrs_pkg::WR_TX_CTRL: txon_nxt = ctl.data[3];
          default: ;
        endcase
        ptr_nxt = scrs_pkg::WR_POINTER;
      end
    end

    if (ctl.rx && rxon_r) begin
      if (fill_r < FW'(DEPTH)) begin
        for (int i = 0; i < DEPTH; i++) begin
          if (fill_r == FW'(i)) begin
            fifo_nxt[i] = ctl.data;
          end
        end
        fill_nxt = fill_r + FW'(1);
      end else begin
        ovr_nxt = 1'b1;
      end
      if (mode_r != 2'b00) begin
        pend_nxt = 1'b1;
      end
    end

    // channel reset from register 9 wins over everything else
    if (ctl.clr) begin
      for (int i = 0; i < DEPTH; i++) begin
        fifo_nxt[i] = 8'h00;
      end
      fill_nxt = '0;
      ovr_nxt  = 1'b0;
      pend_nxt = 1'b0;
      ptr_nxt  = 4'd0;
      txie_nxt = 1'b0;
      mode_nxt = 2'b00;
      rxon_nxt = 1'b0;
      txon_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        fifo_r[i] <= 8'h00;
      end
      fill_r <= '0;
      ovr_r  <= 1'b0;
      pend_r <= 1'b0;
      ptr_r  <= 4'd0;
      txie_r <= 1'b0;
      mode_r <= 2'b00;
      rxon_r <= 1'b0;
      txon_r <= 1'b0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        fifo_r[i] <= fifo_nxt[i];
      end
      fill_r <= fill_nxt;
      ovr_r  <= ovr_nxt;
      pend_r <= pend_nxt;
      ptr_r  <= ptr_nxt;
      txie_r <= txie_nxt;
      mode_r <= mode_nxt;
      rxon_r <= rxon_nxt;
      txon_r <= txon_nxt;
    end
  end

  assign stat.head        = fifo_r[0];
  assign stat.fill_nz     = (fill_r != '0);
  assign stat.overrun     = ovr_r;
  assign stat.pending     = pend_r;
  assign stat.pending_nxt = pend_nxt;
  assign stat.pointer     = ptr_r;
  assign stat.rx_on       = rxon_r;
  assign stat.tx_ie       = txie_r;
  assign stat.tx_on       = txon_r;

endmodule

[rtl/core/scrs_outq.sv]
// Two-entry result queue that decouples result stalls from item acceptance.
// Depends on scrs_pkg.
module scrs_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  scrs_pkg::res_t  push_data,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output scrs_pkg::res_t  out_data
);

  scrs_pkg::res_t q0_r, q0_nxt;
  scrs_pkg::res_t q1_r, q1_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pop;

  assign pop       = (cnt_r != 2'd0) && !out_stall;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = q0_r;

  always_comb begin
    q0_nxt  = q0_r;
    q1_nxt  = q1_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) begin
          q0_nxt = push_data;
        end else begin
          q1_nxt = push_data;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
      2'b01: begin
        q0_nxt  = q1_r;
        cnt_nxt = cnt_r - 2'd1;
      end
      2'b11: begin
        // push never happens when full, so at most one entry is held here
        q0_nxt = push_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= q0_nxt;
    q1_r <= q1_nxt;
  end

endmodule

[rtl/core/serial_controller_register_subset_core.sv]
// Top level of the two-channel serial controller register subset.
// Depends on scrs_pkg, scrs_chan and scrs_outq.

// Takes one item per cycle: a bus read, a bus write or a received byte, and returns exactly
// one result per item. Each item is decoded and applied to the channel registers in the cycle
// it transfers; its result enters a two-entry output queue, and input stalls only when that
// queue holds two results. Bus address bit 1 low selects channel 1, high selects channel 0;
// bit 0 selects the data port. A debug access reads without side effects and makes writes
// do nothing. RX_FIFO_DEPTH sets the receive FIFO depth of each channel.
module serial_controller_register_subset_core #(
  parameter int RX_FIFO_DEPTH = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  scrs_pkg::item_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output scrs_pkg::res_t  out_data
);

  scrs_pkg::chan_ctl_t  ctl  [2];
  scrs_pkg::chan_stat_t stat [2];
  scrs_pkg::chan_stat_t sel;
  scrs_pkg::res_t       res;

  logic       acc;
  logic       q_full;
  logic       csel;
  logic       is_rd, is_wr, is_rx;
  logic       wr9;
  logic       master_r, master_nxt;
  logic [7:0] rd_data;

  assign acc   = in_valid && !in_stall;
  assign in_stall = q_full;
  assign csel  = ~in_data.bus_address[1];
  assign sel   = stat[csel];
  assign is_rd = acc && (in_data.opcode == scrs_pkg::OP_READ);
  assign is_wr = acc && (in_data.opcode == scrs_pkg::OP_WRITE) && !in_data.debug_access;
  assign is_rx = acc && (in_data.opcode == scrs_pkg::OP_RX);

  assign wr9 = is_wr && !in_data.bus_address[0] && (sel.pointer == scrs_pkg::WR_MASTER);
  assign master_nxt = wr9 ? in_data.data_byte[scrs_pkg::MIE_BIT] : master_r;

  for (genvar k = 0; k < 2; k++) begin : g_chan
    assign ctl[k].rd_data = is_rd && in_data.bus_address[0] && !in_data.debug_access &&
                            (csel == 1'(k));
    assign ctl[k].rd_ctl  = is_rd && !in_data.bus_address[0] && !in_data.debug_access &&
                            (csel == 1'(k));
    assign ctl[k].wr_ctl  = is_wr && !in_data.bus_address[0] && (csel == 1'(k));
    assign ctl[k].rx      = is_rx && (in_data.rx_channel == 1'(k));
    assign ctl[k].clr     = wr9 && in_data.data_byte[(k == 0) ? scrs_pkg::RESET_CH0_BIT
                                                              : scrs_pkg::RESET_CH1_BIT];
    assign ctl[k].data    = in_data.data_byte;

    scrs_chan #(
      .DEPTH (RX_FIFO_DEPTH)
    ) u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl[k]),
      .stat  (stat[k])
    );
  end

  always_comb begin
    rd_data = 8'h00;
    if (is_rd) begin
      if (in_data.bus_address[0]) begin
        rd_data = sel.head;
      end else begin
        unique case (sel.pointer)
          scrs_pkg::RR_STATUS:  rd_data = {5'b00000, 1'b1, 1'b0, sel.fill_nz};
          scrs_pkg::RR_ERROR:   rd_data = {2'b00, sel.overrun, 5'b00000};
          scrs_pkg::RR_PENDING: rd_data = scrs_pkg::pend_bits(stat[1].pending, stat[0].pending);
          default:              rd_data = 8'h00;
        endcase
      end
    end
  end

  assign res.read_data       = rd_data;
  assign res.irq_vector_bits = scrs_pkg::pend_bits(stat[1].pending_nxt, stat[0].pending_nxt);
  assign res.master_int_on   = master_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= 1'b0;
    end else begin
      master_r <= master_nxt;
    end
  end

  scrs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Receive pending on channel 0 rises only from a received byte
  a_pend_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stat[0].pending) |-> $past(ctl[0].rx))
    else $error("channel 0 pending set without a received byte");

  // Master enable changes only through a register 9 write
  a_master: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(master_r) |-> $past(wr9))
    else $error("master enable changed without a register 9 write");

  // A channel reset clears the enables of channel 1
  a_clr_ch1: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ctl[1].clr) |-> (!stat[1].rx_on && !stat[1].tx_on && !stat[1].tx_ie))
    else $error("channel 1 enables survived a channel reset");

endmodule
